// File: src/stt_pkg.sv
// Package for the software timer table: operation and result codes, slot flag bits,
// default register values and table size. It depends on nothing else.
package stt_pkg;
    localparam int NumTimersDefault = 16;
    localparam logic [9:0]  TickIntervalReset = 10'd15;
    localparam logic [13:0] MinAccuracyReset  = 14'd100;

    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_CREATE = 3'd1,
        OP_KILL   = 3'd2,
        OP_FIRE   = 3'd3,
        OP_PURGE  = 3'd4
    } t_op;

    localparam logic [2:0] KIND_NONE  = 3'd0;
    localparam logic [2:0] KIND_FIRED = 3'd1;
    localparam logic [2:0] KIND_FEND  = 3'd2;
    localparam logic [2:0] KIND_ENDED = 3'd3;
    localparam logic [2:0] KIND_NEW   = 3'd4;
    localparam logic [2:0] KIND_ERROR = 3'd5;

    localparam int FlagRepeat  = 0;
    localparam int FlagPrecise = 1;
    localparam int FlagNomap   = 2;

    localparam int RegTick = 0;
    localparam int RegAcc  = 1;

    // "t is at or after d" on wrapping 32-bit millisecond counters.
    function automatic logic reached(input logic [31:0] t, input logic [31:0] d);
        logic [31:0] diff;
        diff = t - d;
        return ~diff[31];
    endfunction
endpackage

// File: src/software_timer_table_unit.sv
// Top level of the software timer table: APB register port, item handshake,
// and a slot sequencer that visits one slot per cycle while no result waits to be
// taken, through one shared compare unit. Depends on stt_pkg.
//
// Timing: create, kill, fire now and unknown operations register their result in the
// decode state; once it is taken, the sequencer passes through S_DONE back to S_IDLE
// before it accepts the next item. A tick runs one scan pass per one-shot fired plus
// one, then the coarse pass if the think deadline is reached, and the precise pass;
// purge runs a single pass. Every result waits in its output register until taken, so
// receiver stalls hold the sequencer. Only one item is in flight at a time.
// Reset (synchronous, active low) clears all slots, the time counters and registers
// to their defaults; slot contents are written by create before any read.
module software_timer_table_unit
    import stt_pkg::*;
#(
    parameter int NUM_TIMERS = NumTimersDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_operation,
    input  logic [3:0]  i_slot,
    input  logic [23:0] i_interval,
    input  logic [15:0] i_elapsed,
    input  logic        i_repeat_req,
    input  logic        i_tick_precise,
    input  logic        i_no_mapchange,
    input  logic        i_delay_exec,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_kind,
    output logic [3:0]  o_timer_slot,
    output logic        o_last
);
    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    // Counter one bit wider so it can hold NUM_TIMERS itself.
    localparam int CW = IW + 1;
    localparam logic [CW-1:0] NT = CW'(NUM_TIMERS);

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_ONE_SCAN, S_ONE_FIRE, S_COARSE, S_PRECISE,
        S_THINK, S_PURGE, S_EMIT, S_DONE
    } t_state;

    // Configuration registers; pready is always high.
    logic [9:0]  r_tick_ms;
    logic [13:0] r_acc_ms;
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_ms <= TickIntervalReset;
            r_acc_ms  <= MinAccuracyReset;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == 1'(RegAcc)) r_acc_ms  <= pwdata[13:0];
            else                        r_tick_ms <= pwdata[9:0];
        end
    end
    always_comb begin
        if (paddr[2] == 1'(RegAcc)) prdata = {18'd0, r_acc_ms};
        else                        prdata = {22'd0, r_tick_ms};
    end

    // Slot table. Active bits reset; the rest is written by create before use.
    logic [NUM_TIMERS-1:0] r_active;
    logic [31:0] r_deadline [NUM_TIMERS];
    logic [23:0] r_period   [NUM_TIMERS];
    logic [2:0]  r_flags    [NUM_TIMERS];

    logic [31:0] r_now, r_think_dl;
    logic        r_think;
    t_state      r_state;
    logic [CW-1:0] r_idx;
    logic [2:0]  r_op;
    logic [3:0]  r_slot;
    logic [23:0] r_ivl;
    logic [15:0] r_elapsed;
    logic [2:0]  r_cflags;
    logic        r_delay;
    logic        r_any;       // a result of this item is held back in r_pkind/r_pslot
    logic [2:0]  r_pkind;
    logic [3:0]  r_pslot;
    logic        r_best_ok;
    logic [IW-1:0] r_best;
    logic [31:0] r_best_late;
    logic [2:0]  r_kind;
    logic [3:0]  r_oslot;
    logic        r_olast;
    logic        r_ovalid;
    t_state      r_after;     // where to go after the result is taken

    assign o_ready      = (r_state == S_IDLE);
    assign o_valid      = r_ovalid;
    assign o_kind       = r_kind;
    assign o_timer_slot = r_oslot;
    assign o_last       = r_olast;

    // Shared unit: the current slot, its lateness and the catch-up rearm.
    logic [IW-1:0] cur;
    logic          cur_in;
    logic [31:0]   late, step, base, tol, diff, rearm;
    logic          rep_hit;
    assign cur    = r_idx[IW-1:0];
    assign cur_in = (r_idx < NT);
    assign late   = r_now - r_deadline[cur];
    always_comb begin
        if (r_state == S_THINK) begin
            base = r_think_dl;
            step = {22'd0, r_tick_ms};
            tol  = {18'd0, r_acc_ms};
        end else begin
            base = r_deadline[cur];
            step = {8'd0, r_period[cur]};
            tol  = (r_state == S_PRECISE) ? {22'd0, r_tick_ms} : {18'd0, r_acc_ms};
        end
        diff  = r_now - base - step;
        rearm = (diff[31] || diff <= tol) ? base + step : r_now + step;
    end
    assign rep_hit = cur_in && r_active[cur] && r_flags[cur][FlagRepeat]
                  && (r_flags[cur][FlagPrecise] == (r_state == S_PRECISE))
                  && ~late[31];

    // Lowest free slot for create.
    logic          free_ok;
    logic [IW-1:0] free_idx;
    always_comb begin
        free_ok  = 1'b0;
        free_idx = '0;
        for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
            if (!r_active[i]) begin
                free_ok  = 1'b1;
                free_idx = IW'(i);
            end
        end
    end

    logic slot_ok;
    assign slot_ok = (32'(r_slot) < 32'(NUM_TIMERS)) && r_active[IW'(r_slot)];

    // Scan results are held back by one, so that the final one can carry the last flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_active   <= '0;
            r_now      <= '0;
            r_think_dl <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_op      <= i_operation;
                        r_slot    <= i_slot;
                        r_ivl     <= i_interval;
                        r_elapsed <= i_elapsed;
                        r_cflags  <= {i_no_mapchange, i_tick_precise, i_repeat_req};
                        r_delay   <= i_delay_exec;
                        r_any     <= 1'b0;
                        r_state   <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    r_idx    <= '0;
                    r_olast  <= 1'b1;
                    r_ovalid <= 1'b1;
                    r_after  <= S_DONE;
                    r_state  <= S_EMIT;
                    r_kind   <= KIND_ERROR;
                    r_oslot  <= 4'd0;
                    priority case (r_op)
                        OP_TICK: begin
                            r_now       <= r_now + {16'd0, r_elapsed};
                            r_think     <= reached(r_now + {16'd0, r_elapsed}, r_think_dl);
                            r_best_ok   <= 1'b0;
                            r_best_late <= '0;
                            r_ovalid    <= 1'b0;
                            r_state     <= S_ONE_SCAN;
                        end
                        OP_CREATE: begin
                            if (free_ok) begin
                                r_active[free_idx]   <= 1'b1;
                                r_deadline[free_idx] <= r_now + {8'd0, r_ivl};
                                r_period[free_idx]   <= r_ivl;
                                r_flags[free_idx]    <= r_cflags;
                                r_kind  <= KIND_NEW;
                                r_oslot <= 4'(free_idx);
                            end
                        end
                        OP_KILL, OP_FIRE: begin
                            r_oslot <= r_slot;
                            if (slot_ok) begin
                                if (r_op == OP_KILL) begin
                                    r_active[IW'(r_slot)] <= 1'b0;
                                    r_kind <= KIND_ENDED;
                                end else if (!r_flags[IW'(r_slot)][FlagRepeat]) begin
                                    r_active[IW'(r_slot)] <= 1'b0;
                                    r_kind <= KIND_FEND;
                                end else begin
                                    if (r_delay)
                                        r_deadline[IW'(r_slot)] <=
                                            r_now + {8'd0, r_period[IW'(r_slot)]};
                                    r_kind <= KIND_FIRED;
                                end
                            end
                        end
                        OP_PURGE: begin
                            r_ovalid <= 1'b0;
                            r_state  <= S_PURGE;
                        end
                        default: ;
                    endcase
                end
                S_ONE_SCAN: begin
                    if (cur_in) begin
                        if (r_active[cur] && !r_flags[cur][FlagRepeat] && ~late[31]
                            && (!r_best_ok || late > r_best_late)) begin
                            r_best_ok   <= 1'b1;
                            r_best      <= cur;
                            r_best_late <= late;
                        end
                        r_idx <= r_idx + CW'(1);
                    end else begin
                        r_state <= S_ONE_FIRE;
                    end
                end
                S_ONE_FIRE: begin
                    r_idx <= '0;
                    if (r_best_ok) begin
                        r_active[r_best] <= 1'b0;
                        // Send out the held result, hold this one.
                        r_kind    <= r_pkind;
                        r_oslot   <= r_pslot;
                        r_olast   <= 1'b0;
                        r_ovalid  <= r_any;
                        r_pkind   <= KIND_FEND;
                        r_pslot   <= 4'(r_best);
                        r_any     <= 1'b1;
                        r_best_ok <= 1'b0;
                        r_best_late <= '0;
                        r_after   <= S_ONE_SCAN;
                        r_state   <= r_any ? S_EMIT : S_ONE_SCAN;
                    end else begin
                        r_state <= r_think ? S_COARSE : S_PRECISE;
                    end
                end
                S_COARSE, S_PRECISE: begin
                    if (cur_in) begin
                        r_idx <= r_idx + CW'(1);
                        if (rep_hit) begin
                            r_deadline[cur] <= rearm;
                            r_kind   <= r_pkind;
                            r_oslot  <= r_pslot;
                            r_olast  <= 1'b0;
                            r_ovalid <= r_any;
                            r_pkind  <= KIND_FIRED;
                            r_pslot  <= 4'(cur);
                            r_any    <= 1'b1;
                            r_after  <= r_state;
                            r_state  <= r_any ? S_EMIT : r_state;
                        end
                    end else if (r_state == S_COARSE) begin
                        r_idx   <= '0;
                        r_state <= S_PRECISE;
                    end else begin
                        r_state <= S_THINK;
                    end
                end
                S_THINK: begin
                    if (r_think) r_think_dl <= rearm;
                    // Close the item with the held result, or "none" if nothing came out.
                    r_kind   <= r_any ? r_pkind : KIND_NONE;
                    r_oslot  <= r_any ? r_pslot : 4'd0;
                    r_olast  <= 1'b1;
                    r_ovalid <= 1'b1;
                    r_after  <= S_DONE;
                    r_state  <= S_EMIT;
                end
                S_PURGE: begin
                    if (cur_in) begin
                        r_idx <= r_idx + CW'(1);
                        if (r_active[cur] && r_flags[cur][FlagNomap]) begin
                            r_active[cur] <= 1'b0;
                            r_kind   <= r_pkind;
                            r_oslot  <= r_pslot;
                            r_olast  <= 1'b0;
                            r_ovalid <= r_any;
                            r_pkind  <= KIND_ENDED;
                            r_pslot  <= 4'(cur);
                            r_any    <= 1'b1;
                            r_after  <= S_PURGE;
                            r_state  <= r_any ? S_EMIT : S_PURGE;
                        end
                    end else begin
                        r_kind   <= r_any ? r_pkind : KIND_NONE;
                        r_oslot  <= r_any ? r_pslot : 4'd0;
                        r_olast  <= 1'b1;
                        r_ovalid <= 1'b1;
                        r_after  <= S_DONE;
                        r_state  <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (i_ready) begin
                        r_ovalid <= 1'b0;
                        r_state  <= r_after;
                    end
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// File: tb/software_timer_table_unit_test.sv
// Self-checking testbench for software_timer_table_unit: directed and random items with
// random stalls on both channels, checked against an in-bench predictor of the timer table.
// Depends on stt_pkg and the software_timer_table_unit RTL.
`timescale 1ns / 100ps

module software_timer_table_unit_test;
    import stt_pkg::*;

    localparam int SlotCount = 16;
    // Operation codes beyond the defined set; the block answers them with an error.
    localparam logic [2:0] OpSpareLo  = 3'd5;
    localparam logic [2:0] OpSpareMid = 3'd6;
    localparam logic [2:0] OpSpareHi  = 3'd7;
    // The longest tick runs one scan pass per fired one-shot plus one, then the
    // coarse and precise passes, and the emission of every result.
    localparam int TickLatency = (SlotCount + 1) * (SlotCount + 2) + 3 * SlotCount + 5;

    typedef struct packed {
        logic [2:0] kind;
        logic [3:0] slot;
        logic       last;
    } t_timer_event;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid;
    logic        o_ready;
    logic [2:0]  i_operation;
    logic [3:0]  i_slot;
    logic [23:0] i_interval;
    logic [15:0] i_elapsed;
    logic        i_repeat_req;
    logic        i_tick_precise;
    logic        i_no_mapchange;
    logic        i_delay_exec;
    logic        o_valid;
    logic        i_ready;
    logic [2:0]  o_kind;
    logic [3:0]  o_timer_slot;
    logic        o_last;

    software_timer_table_unit dut (.*);

    // The predicted copy of the timer table and its registers.
    logic [9:0]  tick_ms;
    logic [13:0] accuracy_ms;
    logic        timer_live  [SlotCount];
    logic [31:0] timer_due   [SlotCount];
    logic [23:0] timer_step  [SlotCount];
    logic        timer_rep   [SlotCount];
    logic        timer_prec  [SlotCount];
    logic        timer_nomap [SlotCount];
    logic [31:0] clock_ms;
    logic [31:0] think_due;

    // Events the block still owes, oldest first.
    t_timer_event owed_events[$];

    int mismatches;
    int sender_idle_pct;
    int receiver_stall_pct;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("software_timer_table_unit: mismatch");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // The receiver stalls at random and every accepted result is checked against
    // the oldest owed event, field by field.
    always @(posedge i_clk) begin
        t_timer_event want;
        if (i_rst_n && o_valid && i_ready) begin
            if (owed_events.size() == 0) begin
                report_mismatch("result with nothing owed, kind", o_kind, -1);
            end else begin
                want = owed_events.pop_front();
                if (o_kind !== want.kind) report_mismatch("kind", o_kind, want.kind);
                if (o_timer_slot !== want.slot)
                    report_mismatch("timer_slot", o_timer_slot, want.slot);
                if (o_last !== want.last) report_mismatch("last", o_last, want.last);
            end
        end
        i_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    function automatic t_timer_event make_event(input logic [2:0] kind, input logic [3:0] slot);
        return '{kind, slot, 1'b0};
    endfunction

    function automatic bit has_reached(input logic [31:0] t, input logic [31:0] d);
        logic [31:0] diff;
        diff = t - d;
        return !diff[31];
    endfunction

    // Rearm with catch-up: stay on the grid unless we fell more than tol behind.
    function automatic logic [31:0] rearm(input logic [31:0] prev, input logic [31:0] step,
                                          input logic [31:0] tol);
        logic [31:0] behind;
        behind = clock_ms - prev - step;
        if (behind[31] || behind <= tol) return prev + step;
        return clock_ms + step;
    endfunction

    function automatic void fire_repeating(input bit precise, inout t_timer_event evs[$]);
        for (int s = 0; s < SlotCount; s++) begin
            if (timer_live[s] && timer_rep[s] && timer_prec[s] == precise &&
                has_reached(clock_ms, timer_due[s])) begin
                evs = {evs, make_event(KIND_FIRED, 4'(s))};
                timer_due[s] = rearm(timer_due[s], {8'd0, timer_step[s]},
                                     precise ? {22'd0, tick_ms} : {18'd0, accuracy_ms});
            end
        end
    endfunction

    // Works out every event that one accepted item causes and queues them.
    function automatic void predict_timer_events(input logic [2:0] op, input logic [3:0] slot,
            input logic [23:0] interval, input logic [15:0] elapsed, input logic rep,
            input logic prec, input logic nomap, input logic delay);
        t_timer_event evs[$];
        bit think;
        int pick;
        int free_slot;
        logic [31:0] late;
        logic [31:0] worst;
        case (op)
            OP_TICK: begin
                clock_ms = clock_ms + {16'd0, elapsed};
                think = has_reached(clock_ms, think_due);
                // One-shots go out most overdue first; ties favor the lower slot.
                forever begin
                    pick = -1;
                    worst = '0;
                    for (int s = 0; s < SlotCount; s++) begin
                        if (timer_live[s] && !timer_rep[s] &&
                            has_reached(clock_ms, timer_due[s])) begin
                            late = clock_ms - timer_due[s];
                            if (pick < 0 || late > worst) begin
                                pick = s;
                                worst = late;
                            end
                        end
                    end
                    if (pick < 0) break;
                    timer_live[pick] = 1'b0;
                    evs = {evs, make_event(KIND_FEND, 4'(pick))};
                end
                if (think) fire_repeating(1'b0, evs);
                fire_repeating(1'b1, evs);
                if (think) think_due = rearm(think_due, {22'd0, tick_ms}, {18'd0, accuracy_ms});
            end
            OP_CREATE: begin
                free_slot = -1;
                for (int s = SlotCount - 1; s >= 0; s--) if (!timer_live[s]) free_slot = s;
                if (free_slot < 0) begin
                    evs = {evs, make_event(KIND_ERROR, 4'd0)};
                end else begin
                    timer_live[free_slot]  = 1'b1;
                    timer_due[free_slot]   = clock_ms + {8'd0, interval};
                    timer_step[free_slot]  = interval;
                    timer_rep[free_slot]   = rep;
                    timer_prec[free_slot]  = prec;
                    timer_nomap[free_slot] = nomap;
                    evs = {evs, make_event(KIND_NEW, 4'(free_slot))};
                end
            end
            OP_KILL, OP_FIRE: begin
                if (!timer_live[slot]) begin
                    evs = {evs, make_event(KIND_ERROR, slot)};
                end else if (op == OP_KILL) begin
                    timer_live[slot] = 1'b0;
                    evs = {evs, make_event(KIND_ENDED, slot)};
                end else if (!timer_rep[slot]) begin
                    timer_live[slot] = 1'b0;
                    evs = {evs, make_event(KIND_FEND, slot)};
                end else begin
                    if (delay) timer_due[slot] = clock_ms + {8'd0, timer_step[slot]};
                    evs = {evs, make_event(KIND_FIRED, slot)};
                end
            end
            OP_PURGE: begin
                for (int s = 0; s < SlotCount; s++) begin
                    if (timer_live[s] && timer_nomap[s]) begin
                        timer_live[s] = 1'b0;
                        evs = {evs, make_event(KIND_ENDED, 4'(s))};
                    end
                end
            end
            default: evs = {evs, make_event(KIND_ERROR, 4'd0)};
        endcase
        if (evs.size() == 0) evs = {evs, make_event(KIND_NONE, 4'd0)};
        evs[evs.size() - 1].last = 1'b1;
        owed_events = {owed_events, evs};
    endfunction

    // Presents one item, holding it until the block takes it, then predicts its events.
    task automatic send_item(input logic [2:0] op, input logic [3:0] slot,
            input logic [23:0] interval, input logic [15:0] elapsed, input logic rep,
            input logic prec, input logic nomap, input logic delay);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_operation    <= op;
        i_slot         <= slot;
        i_interval     <= interval;
        i_elapsed      <= elapsed;
        i_repeat_req   <= rep;
        i_tick_precise <= prec;
        i_no_mapchange <= nomap;
        i_delay_exec   <= delay;
        do @(posedge i_clk); while (!o_ready);
        predict_timer_events(op, slot, interval, elapsed, rep, prec, nomap, delay);
    endtask

    // Lowers valid and waits until every owed event has come out, plus a margin.
    task automatic drain_events();
        i_valid <= 1'b0;
        while (owed_events.size() != 0) @(posedge i_clk);
        repeat (TickLatency + 20) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle; pready is always high.
    task automatic write_register(input int index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(index * 4);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (index == RegTick) tick_ms = value[9:0];
        else if (index == RegAcc) accuracy_ms = value[13:0];
    endtask

    task automatic set_timing(input int tick_value, input int accuracy_value);
        write_register(RegTick, tick_value);
        write_register(RegAcc, accuracy_value);
    endtask

    // Extremes of every field, every operation, and each corner the table has.
    task automatic test_directed();
        // Zero-length one-shot, fired and freed by the very next tick.
        send_item(OP_CREATE, 4'd0, 24'd0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_item(OP_TICK, 4'd0, 24'd0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        // Fill the table with a mix of kinds, then ask for one more: table full.
        for (int s = 0; s < SlotCount; s++)
            send_item(OP_CREATE, 4'(s), (s == 15) ? 24'hFFFFFF : 24'(s * 7),
                      16'd0, s[0], s[1], s[2], 1'b0);
        send_item(OP_CREATE, 4'd0, 24'd5, 16'd0, 1'b1, 1'b1, 1'b1, 1'b1);
        send_item(OP_KILL, 4'd3, 24'd0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        // Killing a dead slot is an error carrying the slot number.
        send_item(OP_KILL, 4'd3, 24'd0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_item(OP_FIRE, 4'd0, 24'd0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_item(OP_FIRE, 4'd1, 24'd0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b1);
        send_item(OP_PURGE, 4'd0, 24'd0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_item(OpSpareLo, 4'hF, 24'd0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_item(OpSpareMid, 4'd0, 24'd0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_item(OpSpareHi, 4'd0, 24'd0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        // A long jump forces catch-up on every repeating timer.
        send_item(OP_TICK, 4'd0, 24'd0, 16'hFFFF, 1'b0, 1'b0, 1'b0, 1'b0);
        send_item(OP_TICK, 4'd0, 24'd0, 16'd1, 1'b0, 1'b0, 1'b0, 1'b0);
        drain_events();
    endtask

    // Random items shaped so that the table keeps filling, firing and emptying.
    task automatic test_random(input int count, input int idle_pct, input int stall_pct);
        logic [2:0] op;
        logic [23:0] interval;
        logic [15:0] elapsed;
        int roll;
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(99);
            if (roll < 32) op = OP_CREATE;
            else if (roll < 67) op = OP_TICK;
            else if (roll < 78) op = OP_KILL;
            else if (roll < 89) op = OP_FIRE;
            else if (roll < 95) op = OP_PURGE;
            else op = 3'($urandom_range(OpSpareLo, OpSpareHi));
            interval = ($urandom_range(9) == 0) ? 24'($urandom) : 24'($urandom_range(300));
            elapsed  = ($urandom_range(14) == 0) ? 16'($urandom) : 16'($urandom_range(80));
            send_item(op, 4'($urandom), interval, elapsed, 1'($urandom), 1'($urandom),
                      1'($urandom), 1'($urandom));
            // Once, hold the sender back until the block has caught up completely.
            if (n == count / 2 && idle_pct == 0) begin
                i_valid <= 1'b0;
                while (owed_events.size() != 0) @(posedge i_clk);
            end
        end
        drain_events();
    endtask

    initial begin
        mismatches = 0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        tick_ms = TickIntervalReset;
        accuracy_ms = MinAccuracyReset;
        clock_ms = 0;
        think_due = 0;
        foreach (timer_live[s]) timer_live[s] = 1'b0;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_operation = OP_TICK;
        i_slot = '0;
        i_interval = '0;
        i_elapsed = '0;
        i_repeat_req = 1'b0;
        i_tick_precise = 1'b0;
        i_no_mapchange = 1'b0;
        i_delay_exec = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(35, 0, 0);
        set_timing(1, 1);
        test_random(35, 83, 0);
        set_timing(1000, 10000);
        test_random(35, 0, 83);
        set_timing(37, 250);
        test_random(35, 38, 38);

        if (mismatches == 0) begin
            $display("software_timer_table_unit: match");
        end else begin
            $display("software_timer_table_unit: mismatch");
        end
        $finish;
    end
endmodule

// File: software_timer_table_unit.f
src/stt_pkg.sv
src/software_timer_table_unit.sv
tb/software_timer_table_unit_test.sv
